// ===== rtl/pbcd_pkg.sv =====
// ----------------------------------------------------------------------------
// pbcd_pkg: shared types and constants of the block cache directory
// Actions, status codes, probe step factors and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package pbcd_pkg;

  localparam int unsigned SlotW      = 12;
  localparam int unsigned Slots      = 1 << SlotW;
  localparam int unsigned ProbeDepth = 8;
  localparam int unsigned ProbeCntW  = $clog2(ProbeDepth + 1);
  localparam logic [SlotW-1:0] StepAdd = SlotW'(3697);

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_FIND   = 3'd1,
    ACT_UPDATE = 3'd2,
    ACT_ERASE  = 3'd3,
    ACT_SWEEP  = 3'd4,
    ACT_FLUSH  = 3'd5
  } action_e;

  typedef enum logic [3:0] {
    ST_NEW      = 4'd0,
    ST_EXISTING = 4'd1,
    ST_EVICTED  = 4'd2,
    ST_MISS     = 4'd3,
    ST_OVERFLOW = 4'd4,
    ST_UPDATED  = 4'd5,
    ST_ERASED   = 4'd6,
    ST_KEPT     = 4'd7,
    ST_SWEPT    = 4'd8,
    ST_EMPTY    = 4'd9,
    ST_FLUSH    = 4'd10
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_WAIT,
    S_EVAL,
    S_STEP,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] block_id;
    logic [31:0] handle_in;
    logic        modify;
    logic [11:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] handle_out;
    logic [31:0] released_handle;
    logic [31:0] released_block_id;
    logic        released_changed;
  } rsp_t;

  typedef struct packed {
    logic [31:0] block_id;
    logic [31:0] handle;
    logic        used;
    logic        changed;
  } slot_t;

  function automatic logic [SlotW-1:0] step_factor(input logic [3:0] sel);
    logic [SlotW-1:0] f;
    case (sel)
      4'd0:    f = SlotW'(557);
      4'd1:    f = SlotW'(709);
      4'd2:    f = SlotW'(797);
      4'd3:    f = SlotW'(977);
      4'd4:    f = SlotW'(1109);
      4'd5:    f = SlotW'(1249);
      4'd6:    f = SlotW'(1297);
      4'd7:    f = SlotW'(1657);
      4'd8:    f = SlotW'(2297);
      4'd9:    f = SlotW'(2309);
      4'd10:   f = SlotW'(2377);
      4'd11:   f = SlotW'(2417);
      4'd12:   f = SlotW'(3049);
      4'd13:   f = SlotW'(3229);
      4'd14:   f = SlotW'(3709);
      default: f = SlotW'(3761);
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pbcd_if.sv =====
// ----------------------------------------------------------------------------
// pbcd_req_if / pbcd_rsp_if: valid/ready channels of the directory
// Request and response transaction channels with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbcd_req_if;
  logic          valid;
  logic          ready;
  pbcd_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pbcd_rsp_if;
  logic          valid;
  logic          ready;
  pbcd_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/probed_block_cache_directory.sv =====
// ----------------------------------------------------------------------------
// probed_block_cache_directory: open-addressed block cache directory
// Maps block ids to buffer handles with used/changed marks and probing.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | action, block_id, handle_in, modify, slot_index
//  rsp     | out | status, handle_out, released_handle, released_block_id,
//          |     | released_changed
//
// Each probe passes through read, memory wait, compare and step to the next
// slot; the last one skips the step, and the output state then loads the
// result. At most 8 slots are probed per transaction; a rejected request
// goes from read straight to the output state.
// After reset a clearing pass writes all 4096 slots, one per cycle; no
// request is taken until it ends. The result waits in an output register and
// the next request is taken once it leaves.
`default_nettype none

module probed_block_cache_directory (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  pbcd_req_if.sink   req_i,
  pbcd_rsp_if.source rsp_o
);

  localparam int unsigned SW = pbcd_pkg::SlotW;
  localparam int unsigned CW = pbcd_pkg::ProbeCntW;

  pbcd_pkg::state_e state_q, state_d;
  pbcd_pkg::req_t   req_q;
  pbcd_pkg::rsp_t   rsp_q, rsp_d;
  logic             rsp_vld_q;
  logic [SW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [SW:0]      clr_q;
  logic [SW-1:0]    prod_q;

  pbcd_pkg::slot_t  rd, wdata;
  logic             we;
  logic [SW-1:0]    waddr;
  logic             take, hit, empty, bad;

  assign take  = req_i.valid && req_i.ready;
  assign hit   = (rd.block_id == req_q.block_id);
  assign empty = (rd.block_id == 32'd0);
  assign bad   = (req_q.action <= 3'(pbcd_pkg::ACT_ERASE)) && (req_q.block_id == 32'd0)
                 || (req_q.action > 3'(pbcd_pkg::ACT_FLUSH));

  assign req_i.ready   = (state_q == pbcd_pkg::S_IDLE) && !rsp_vld_q;
  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.payload = rsp_q;

  pbcd_store u_store (
    .clk_i   (clk_i),
    .raddr_i (idx_q),
    .rdata_o (rd),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      pbcd_pkg::S_IDLE:  if (take) state_d = pbcd_pkg::S_READ;
      pbcd_pkg::S_CLEAR: if (clr_q[SW]) state_d = pbcd_pkg::S_IDLE;
      pbcd_pkg::S_READ:  state_d = bad ? pbcd_pkg::S_OUT : pbcd_pkg::S_WAIT;
      pbcd_pkg::S_WAIT:  state_d = pbcd_pkg::S_EVAL;
      pbcd_pkg::S_EVAL: begin
        if (req_q.action >= 3'(pbcd_pkg::ACT_SWEEP)) begin
          state_d = pbcd_pkg::S_OUT;
        end else if (req_q.action == 3'(pbcd_pkg::ACT_INSERT)
                     && (empty || hit || !rd.used)) begin
          state_d = pbcd_pkg::S_OUT;
        end else if (req_q.action != 3'(pbcd_pkg::ACT_INSERT) && hit) begin
          state_d = pbcd_pkg::S_OUT;
        end else if (cnt_q == CW'(pbcd_pkg::ProbeDepth - 1)) begin
          state_d = pbcd_pkg::S_OUT;
        end else begin
          state_d = pbcd_pkg::S_STEP;
        end
      end
      pbcd_pkg::S_STEP:  state_d = pbcd_pkg::S_READ;
      pbcd_pkg::S_OUT:   state_d = pbcd_pkg::S_IDLE;
      default:           state_d = pbcd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rsp_d = rsp_q;
    idx_d = idx_q;
    cnt_d = cnt_q;
    we    = 1'b0;
    waddr = idx_q;
    wdata = rd;
    case (state_q)
      pbcd_pkg::S_IDLE: begin
        if (take) begin
          idx_d = (req_i.payload.action >= 3'(pbcd_pkg::ACT_SWEEP))
                  ? req_i.payload.slot_index : req_i.payload.block_id[SW-1:0];
          cnt_d = '0;
        end
      end
      pbcd_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q[SW-1:0];
        wdata = '0;
      end
      pbcd_pkg::S_READ: begin
        rsp_d = '0;
        rsp_d.status = pbcd_pkg::ST_MISS;
        if (req_q.action == 3'(pbcd_pkg::ACT_INSERT) && !bad) begin
          rsp_d.status     = pbcd_pkg::ST_OVERFLOW;
          rsp_d.handle_out = req_q.handle_in;
        end
      end
      pbcd_pkg::S_EVAL: begin
        case (req_q.action)
          3'(pbcd_pkg::ACT_INSERT): begin
            if (hit) begin
              rsp_d.status          = pbcd_pkg::ST_EXISTING;
              rsp_d.handle_out      = rd.handle;
              rsp_d.released_handle = req_q.handle_in;
              we            = 1'b1;
              wdata.used    = 1'b1;
              wdata.changed = rd.changed | req_q.modify;
            end else if (empty || !rd.used) begin
              rsp_d.status = empty ? pbcd_pkg::ST_NEW : pbcd_pkg::ST_EVICTED;
              if (!empty) begin
                rsp_d.released_handle   = rd.handle;
                rsp_d.released_block_id = rd.block_id;
                rsp_d.released_changed  = rd.changed;
              end
              we    = 1'b1;
              wdata = '{block_id: req_q.block_id, handle: req_q.handle_in,
                        used: 1'b1, changed: req_q.modify};
            end
          end
          3'(pbcd_pkg::ACT_FIND): if (hit) begin
            rsp_d.status     = pbcd_pkg::ST_EXISTING;
            rsp_d.handle_out = rd.handle;
            we            = 1'b1;
            wdata.used    = 1'b1;
            wdata.changed = rd.changed | req_q.modify;
          end
          3'(pbcd_pkg::ACT_UPDATE): if (hit) begin
            rsp_d.status     = pbcd_pkg::ST_UPDATED;
            rsp_d.handle_out = req_q.handle_in;
            we    = 1'b1;
            wdata = '{block_id: rd.block_id, handle: req_q.handle_in,
                      used: 1'b1, changed: 1'b1};
          end
          3'(pbcd_pkg::ACT_ERASE): if (hit) begin
            rsp_d.status            = pbcd_pkg::ST_ERASED;
            rsp_d.released_handle   = rd.handle;
            rsp_d.released_block_id = rd.block_id;
            we    = 1'b1;
            wdata = '0;
          end
          3'(pbcd_pkg::ACT_SWEEP): begin
            if (empty) begin
              rsp_d.status = pbcd_pkg::ST_EMPTY;
            end else if (!rd.used && !rd.changed) begin
              rsp_d.status            = pbcd_pkg::ST_SWEPT;
              rsp_d.released_handle   = rd.handle;
              rsp_d.released_block_id = rd.block_id;
              we    = 1'b1;
              wdata = '0;
            end else begin
              rsp_d.status = pbcd_pkg::ST_KEPT;
              we         = 1'b1;
              wdata.used = 1'b0;
            end
          end
          default: begin
            if (empty) begin
              rsp_d.status = pbcd_pkg::ST_EMPTY;
            end else if (rd.changed) begin
              rsp_d.status            = pbcd_pkg::ST_FLUSH;
              rsp_d.handle_out        = rd.handle;
              rsp_d.released_block_id = rd.block_id;
              rsp_d.released_changed  = 1'b1;
              we            = 1'b1;
              wdata.changed = 1'b0;
            end else begin
              rsp_d.status = pbcd_pkg::ST_KEPT;
            end
          end
        endcase
      end
      pbcd_pkg::S_STEP: begin
        idx_d = prod_q + pbcd_pkg::StepAdd;
        cnt_d = cnt_q + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) req_q <= req_i.payload;
    rsp_q  <= rsp_d;
    idx_q  <= idx_d;
    prod_q <= SW'(idx_q * pbcd_pkg::step_factor(req_q.block_id[3:0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pbcd_pkg::S_CLEAR;
      cnt_q     <= '0;
      clr_q     <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == pbcd_pkg::S_CLEAR) clr_q <= clr_q + (SW+1)'(1);
      if (state_q == pbcd_pkg::S_OUT) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != pbcd_pkg::S_IDLE) |-> !req_i.ready)
    else $error("request taken while busy");
  a_out_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pbcd_pkg::S_OUT) |=> rsp_o.valid)
    else $error("result not presented");
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pbcd_pkg::S_STEP) |-> (cnt_q < CW'(pbcd_pkg::ProbeDepth - 1)))
    else $error("probe count overrun");

endmodule

`default_nettype wire

// ===== rtl/pbcd_store.sv =====
// ----------------------------------------------------------------------------
// pbcd_store: slot memory of the directory
// One write port and one registered read port over all slots.
// ----------------------------------------------------------------------------
`default_nettype none

module pbcd_store (
  input  wire logic                       clk_i,
  input  wire logic [pbcd_pkg::SlotW-1:0] raddr_i,
  output pbcd_pkg::slot_t                 rdata_o,
  input  wire logic                       we_i,
  input  wire logic [pbcd_pkg::SlotW-1:0] waddr_i,
  input  wire pbcd_pkg::slot_t            wdata_i
);

  pbcd_pkg::slot_t mem_q [pbcd_pkg::Slots];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== tb/sv/probed_block_cache_directory_tb.sv =====
// ----------------------------------------------------------------------------
// probed_block_cache_directory_tb: self-checking bench of the block directory
// Drives random and directed request transactions, predicts each response
// with a local directory model and compares every response field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module probed_block_cache_directory_tb;

  localparam int unsigned Depth    = pbcd_pkg::ProbeDepth;
  localparam int unsigned MaxCycle = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pbcd_req_if req_if ();
  pbcd_rsp_if rsp_if ();

  probed_block_cache_directory u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #4 clk_i = ~clk_i;

  logic [31:0] dir_id [pbcd_pkg::Slots];
  logic [31:0] dir_handle [pbcd_pkg::Slots];
  logic        dir_used [pbcd_pkg::Slots];
  logic        dir_changed [pbcd_pkg::Slots];

  pbcd_pkg::rsp_t expected_rsp_q [$];
  logic [31:0]    live_ids [$];
  int unsigned    mismatch_cnt;
  int unsigned    cycle_cnt;
  int unsigned    idle_pct;

  function automatic logic [pbcd_pkg::SlotW-1:0] probe_next(
      logic [pbcd_pkg::SlotW-1:0] idx, logic [31:0] id);
    logic [pbcd_pkg::SlotW-1:0] f;
    case (id[3:0])
      4'd0: f = 12'(557);   4'd1: f = 12'(709);   4'd2: f = 12'(797);
      4'd3: f = 12'(977);   4'd4: f = 12'(1109);  4'd5: f = 12'(1249);
      4'd6: f = 12'(1297);  4'd7: f = 12'(1657);  4'd8: f = 12'(2297);
      4'd9: f = 12'(2309);  4'd10: f = 12'(2377); 4'd11: f = 12'(2417);
      4'd12: f = 12'(3049); 4'd13: f = 12'(3229); 4'd14: f = 12'(3709);
      default: f = 12'(3761);
    endcase
    return 12'(idx * f + 12'(3697));
  endfunction

  function automatic int locate_block(logic [31:0] id);
    logic [pbcd_pkg::SlotW-1:0] idx;
    idx = id[pbcd_pkg::SlotW-1:0];
    for (int n = 0; n < Depth; n++) begin
      if (dir_id[idx] == id) return int'(idx);
      idx = probe_next(idx, id);
    end
    return -1;
  endfunction

  function automatic void drop_slot(int s);
    dir_id[s] = '0;
    dir_handle[s] = '0;
    dir_used[s] = 1'b0;
    dir_changed[s] = 1'b0;
  endfunction

  function automatic pbcd_pkg::rsp_t directory_predict(pbcd_pkg::req_t rq);
    pbcd_pkg::rsp_t r;
    logic [2:0] act;
    logic [pbcd_pkg::SlotW-1:0] idx;
    int s;
    bit done;
    r = '0;
    r.status = pbcd_pkg::ST_MISS;
    act = rq.action;
    if (act <= pbcd_pkg::ACT_ERASE && rq.block_id == 0) act = 3'd7;
    s = int'(rq.slot_index);
    case (act)
      pbcd_pkg::ACT_INSERT: begin
        idx = rq.block_id[pbcd_pkg::SlotW-1:0];
        r.status = pbcd_pkg::ST_OVERFLOW;
        r.handle_out = rq.handle_in;
        done = 0;
        for (int n = 0; n < Depth && !done; n++) begin
          if (dir_id[idx] == 0) begin
            r.status = pbcd_pkg::ST_NEW;
            done = 1;
          end else if (dir_id[idx] == rq.block_id) begin
            r.status = pbcd_pkg::ST_EXISTING;
            r.handle_out = dir_handle[idx];
            r.released_handle = rq.handle_in;
            dir_used[idx] = 1'b1;
            if (rq.modify) dir_changed[idx] = 1'b1;
            return r;
          end else if (!dir_used[idx]) begin
            r.status = pbcd_pkg::ST_EVICTED;
            r.released_handle = dir_handle[idx];
            r.released_block_id = dir_id[idx];
            r.released_changed = dir_changed[idx];
            done = 1;
          end else begin
            idx = probe_next(idx, rq.block_id);
          end
          if (done) begin
            dir_id[idx] = rq.block_id;
            dir_handle[idx] = rq.handle_in;
            dir_used[idx] = 1'b1;
            dir_changed[idx] = rq.modify;
          end
        end
      end
      pbcd_pkg::ACT_FIND: begin
        s = locate_block(rq.block_id);
        if (s >= 0) begin
          dir_used[s] = 1'b1;
          if (rq.modify) dir_changed[s] = 1'b1;
          r.status = pbcd_pkg::ST_EXISTING;
          r.handle_out = dir_handle[s];
        end
      end
      pbcd_pkg::ACT_UPDATE: begin
        s = locate_block(rq.block_id);
        if (s >= 0) begin
          dir_handle[s] = rq.handle_in;
          dir_used[s] = 1'b1;
          dir_changed[s] = 1'b1;
          r.status = pbcd_pkg::ST_UPDATED;
          r.handle_out = rq.handle_in;
        end
      end
      pbcd_pkg::ACT_ERASE: begin
        s = locate_block(rq.block_id);
        if (s >= 0) begin
          r.released_handle = dir_handle[s];
          r.released_block_id = dir_id[s];
          drop_slot(s);
          r.status = pbcd_pkg::ST_ERASED;
        end
      end
      pbcd_pkg::ACT_SWEEP: begin
        if (dir_id[s] == 0) begin
          r.status = pbcd_pkg::ST_EMPTY;
        end else if (!dir_used[s] && !dir_changed[s]) begin
          r.released_handle = dir_handle[s];
          r.released_block_id = dir_id[s];
          drop_slot(s);
          r.status = pbcd_pkg::ST_SWEPT;
        end else begin
          dir_used[s] = 1'b0;
          r.status = pbcd_pkg::ST_KEPT;
        end
      end
      pbcd_pkg::ACT_FLUSH: begin
        if (dir_id[s] == 0) begin
          r.status = pbcd_pkg::ST_EMPTY;
        end else if (dir_changed[s]) begin
          r.handle_out = dir_handle[s];
          r.released_block_id = dir_id[s];
          r.released_changed = 1'b1;
          dir_changed[s] = 1'b0;
          r.status = pbcd_pkg::ST_FLUSH;
        end else begin
          r.status = pbcd_pkg::ST_KEPT;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    mismatch_cnt++;
    $display("mismatch %s: got %h expected %h", what, got, exp);
  endtask

  task automatic send_request(logic [2:0] act, logic [31:0] id, logic [31:0] h,
                              logic m, logic [11:0] si);
    pbcd_pkg::req_t rq;
    rq.action = act;
    rq.block_id = id;
    rq.handle_in = h;
    rq.modify = m;
    rq.slot_index = si;
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.payload <= rq;
    req_if.valid <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    expected_rsp_q.insert(expected_rsp_q.size(), directory_predict(rq));
    if (act == pbcd_pkg::ACT_INSERT && id != 0) live_ids.insert(live_ids.size(), id);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk_i) begin
    pbcd_pkg::rsp_t exp;
    cycle_cnt++;
    if (cycle_cnt > MaxCycle) begin
      $display("** probed_block_cache_directory: FAILED **");
      $finish;
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("unexpected transaction", 32'(rsp_if.payload.status), 32'd0);
      end else begin
        exp = expected_rsp_q.pop_front();
        if (rsp_if.payload.status !== exp.status)
          report_mismatch("status", 32'(rsp_if.payload.status), 32'(exp.status));
        if (rsp_if.payload.handle_out !== exp.handle_out)
          report_mismatch("handle_out", rsp_if.payload.handle_out, exp.handle_out);
        if (rsp_if.payload.released_handle !== exp.released_handle)
          report_mismatch("released_handle", rsp_if.payload.released_handle,
                          exp.released_handle);
        if (rsp_if.payload.released_block_id !== exp.released_block_id)
          report_mismatch("released_block_id", rsp_if.payload.released_block_id,
                          exp.released_block_id);
        if (rsp_if.payload.released_changed !== exp.released_changed)
          report_mismatch("released_changed", 32'(rsp_if.payload.released_changed),
                          32'(exp.released_changed));
      end
    end
  end

  function automatic logic [31:0] pick_id();
    logic [31:0] hi;
    if (live_ids.size() > 0 && $urandom_range(3) != 0)
      return live_ids[$urandom_range(live_ids.size() - 1)];
    hi = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(3));
    return (hi << 12) | 32'($urandom_range(15) * 256 + $urandom_range(15));
  endfunction

  task automatic test_directed();
    send_request(pbcd_pkg::ACT_FIND, 32'h0000_0123, '0, 1'b0, '0);
    send_request(pbcd_pkg::ACT_INSERT, 32'h0000_0123, 32'hffff_ffff, 1'b1, '0);
    send_request(pbcd_pkg::ACT_INSERT, 32'h0000_0123, 32'h1234_5678, 1'b0, '0);
    send_request(pbcd_pkg::ACT_FIND, 32'h0000_0123, '0, 1'b1, '0);
    send_request(pbcd_pkg::ACT_UPDATE, 32'h0000_0123, 32'h0000_0001, 1'b0, '0);
    send_request(pbcd_pkg::ACT_FLUSH, '0, '0, 1'b0, 12'h123);
    send_request(pbcd_pkg::ACT_FLUSH, '0, '0, 1'b0, 12'h123);
    send_request(pbcd_pkg::ACT_SWEEP, '0, '0, 1'b0, 12'h123);
    send_request(pbcd_pkg::ACT_SWEEP, '0, '0, 1'b0, 12'h123);
    send_request(pbcd_pkg::ACT_SWEEP, '0, '0, 1'b0, 12'hfff);
    send_request(pbcd_pkg::ACT_FLUSH, '0, '0, 1'b0, 12'h000);
    send_request(pbcd_pkg::ACT_INSERT, 32'hffff_ffff, 32'haaaa_5555, 1'b0, '0);
    send_request(pbcd_pkg::ACT_ERASE, 32'hffff_ffff, '0, 1'b0, '0);
    send_request(pbcd_pkg::ACT_ERASE, 32'hffff_ffff, '0, 1'b0, '0);
    send_request(pbcd_pkg::ACT_INSERT, '0, 32'h5555_aaaa, 1'b1, '0);
    send_request(pbcd_pkg::ACT_FIND, '0, '0, 1'b0, '0);
    send_request(3'd6, 32'h1, 32'h1, 1'b1, 12'h1);
    send_request(3'd7, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 12'hfff);
  endtask

  task automatic test_overflow_and_evict();
    for (int k = 1; k <= 10; k++)
      send_request(pbcd_pkg::ACT_INSERT, 32'h0000_0777 | (32'(k) << 12), 32'(k), 1'(k), '0);
    send_request(pbcd_pkg::ACT_SWEEP, '0, '0, 1'b0, 12'h777);
    send_request(pbcd_pkg::ACT_INSERT, 32'h00ff_0777, 32'hbeef, 1'b0, '0);
  endtask

  task automatic test_random(int unsigned n);
    int unsigned r;
    logic [31:0] id;
    for (int unsigned i = 0; i < n; i++) begin
      idle_pct = (i >= n / 3 && i < n / 2) ? 0 : 35;
      r = $urandom_range(99);
      id = pick_id();
      if (r < 35)
        send_request(pbcd_pkg::ACT_INSERT, id, $urandom(), 1'($urandom()), 12'($urandom()));
      else if (r < 55)
        send_request(pbcd_pkg::ACT_FIND, id, $urandom(), 1'($urandom()), 12'($urandom()));
      else if (r < 65)
        send_request(pbcd_pkg::ACT_UPDATE, id, $urandom(), 1'($urandom()), 12'($urandom()));
      else if (r < 73)
        send_request(pbcd_pkg::ACT_ERASE, id, $urandom(), 1'($urandom()), 12'($urandom()));
      else if (r < 97)
        send_request(3'(pbcd_pkg::ACT_SWEEP + $urandom_range(1)), $urandom(), $urandom(),
                     1'($urandom()), $urandom_range(3) == 0 ? 12'($urandom()) : id[11:0]);
      else
        send_request(3'($urandom_range(7)), $urandom_range(1) ? 32'h0 : id, $urandom(),
                     1'($urandom()), 12'($urandom()));
    end
    idle_pct = 35;
  endtask

  initial begin
    for (int i = 0; i < pbcd_pkg::Slots; i++) drop_slot(i);
    mismatch_cnt = 0;
    cycle_cnt = 0;
    idle_pct = 35;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    rsp_if.ready = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_overflow_and_evict();
    test_random(1300);
    req_if.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_rsp_q.size() == 0)
      $display("** probed_block_cache_directory: PASSED **");
    else
      $display("** probed_block_cache_directory: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/pbcd_pkg.sv
rtl/pbcd_if.sv
rtl/pbcd_store.sv
rtl/probed_block_cache_directory.sv
tb/sv/probed_block_cache_directory_tb.sv
